// ===== design/sau_pkg.sv =====
// shared constants and types for the stack arithmetic unit
package sau_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ITER_W      = $clog2(DATA_W);

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_CALC,
    S_FIX
  } state_t;

endpackage

// ===== design/stack_arithmetic_unit_core.sv =====
// stack arithmetic unit: operand stack with a bit-serial arithmetic datapath
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. Push, unused opcodes and every flagged case finish at
// once: the result is strobed in the cycle after the request and busy never
// rises, so a new request may follow in the next cycle. Add, sub, mul, div
// and mod keep busy high through S_LOAD, which reads the second entry from
// the stack memory, S_CALC, which runs the one-bit-per-cycle loop (serial
// add, shift-add multiply, restoring divide), and S_FIX, which fixes the
// sign and writes back, then strobes the result. The top entry lives in a
// register; the rest of the stack is a memory with a registered read.
module stack_arithmetic_unit_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [2:0]                      opcode,
  input  logic signed [sau_pkg::DATA_W-1:0] push_value,
  output logic                            busy,
  output logic                            done,
  output logic [1:0]                      status,
  output logic signed [sau_pkg::DATA_W-1:0] top_value,
  output logic [sau_pkg::CNT_W-1:0]       stack_count
);
  import sau_pkg::*;

  state_t state, state_next;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] top;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [2:0]        op_r;
  logic [DATA_W-1:0] sa, sb, res, rem;
  logic              carry;
  logic              neg;
  logic [ITER_W-1:0] iter;
  logic [1:0]        status_r;

  logic              accept, is_push, is_arith, is_divmod, short, divz, full;
  logic              mem_we;
  logic [DATA_W-1:0] fixed;
  logic [DATA_W:0]   trial;
  logic              bb, sbit;

  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);

  assign accept    = start && (state == S_IDLE);
  assign is_push   = (opcode == OP_PUSH);
  assign is_arith  = !is_push && (opcode <= OP_MOD);
  assign is_divmod = (opcode == OP_DIV) || (opcode == OP_MOD);
  assign short     = (count < CNT_W'(2));
  assign divz      = is_divmod && (top == '0);
  assign full      = (count == CNT_W'(STACK_DEPTH));
  // the old top moves into the memory on a push onto a non-empty stack that is not full
  assign mem_we    = accept && is_push && !full && (count != '0);

  // restoring divide trial and serial add bit
  assign trial = {rem, sa[DATA_W-1]} - {1'b0, sb};
  assign bb    = (op_r == OP_SUB) ? ~sb[0] : sb[0];
  assign sbit  = sa[0] ^ bb ^ carry;

  always_comb begin
    case (op_r)
      OP_DIV:  fixed = neg ? (~res + DATA_W'(1)) : res;
      OP_MOD:  fixed = neg ? (~rem + DATA_W'(1)) : rem;
      default: fixed = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (accept && is_arith && !short && !divz) state_next = S_LOAD;
      end
      S_LOAD: state_next = S_CALC;
      S_CALC: begin
        if (iter == ITER_W'(DATA_W - 1)) state_next = S_FIX;
      end
      S_FIX:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_m1[ADDR_W-1:0]] <= top;
    rd_data <= mem[cnt_m2[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r <= opcode;
            if (is_push) begin
              done <= 1'b1;
              if (full) begin
                status_r <= ST_FULL;
              end else begin
                top      <= push_value;
                count    <= count + CNT_W'(1);
                status_r <= ST_OK;
              end
            end else if (!is_arith) begin
              done     <= 1'b1;
              status_r <= ST_OK;
            end else if (short) begin
              done     <= 1'b1;
              status_r <= ST_SHORT;
            end else if (divz) begin
              done     <= 1'b1;
              status_r <= ST_DIVZERO;
            end
          end
        end
        S_LOAD: begin
          iter  <= '0;
          carry <= (op_r == OP_SUB);
          res   <= '0;
          rem   <= '0;
          if (op_r == OP_DIV || op_r == OP_MOD) begin
            sa  <= rd_data[DATA_W-1] ? (~rd_data + DATA_W'(1)) : rd_data;
            sb  <= top[DATA_W-1] ? (~top + DATA_W'(1)) : top;
            neg <= (op_r == OP_DIV) ? (rd_data[DATA_W-1] ^ top[DATA_W-1])
                                    : rd_data[DATA_W-1];
          end else begin
            sa  <= rd_data;
            sb  <= top;
            neg <= 1'b0;
          end
        end
        S_CALC: begin
          iter <= iter + ITER_W'(1);
          case (op_r)
            OP_MUL: begin
              // msb-first shift-add, low word only
              res <= {res[DATA_W-2:0], 1'b0} + (sb[DATA_W-1] ? sa : '0);
              sb  <= {sb[DATA_W-2:0], 1'b0};
            end
            OP_DIV, OP_MOD: begin
              if (!trial[DATA_W]) begin
                rem <= trial[DATA_W-1:0];
                res <= {res[DATA_W-2:0], 1'b1};
              end else begin
                rem <= {rem[DATA_W-2:0], sa[DATA_W-1]};
                res <= {res[DATA_W-2:0], 1'b0};
              end
              sa <= {sa[DATA_W-2:0], 1'b0};
            end
            default: begin
              // lsb-first serial add or subtract
              res   <= {sbit, res[DATA_W-1:1]};
              carry <= (sa[0] & bb) | (carry & (sa[0] ^ bb));
              sa    <= {1'b0, sa[DATA_W-1:1]};
              sb    <= {1'b0, sb[DATA_W-1:1]};
            end
          endcase
        end
        S_FIX: begin
          top      <= fixed;
          count    <= cnt_m1;
          status_r <= ST_OK;
          done     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status      = status_r;
  assign top_value   = (count == '0) ? '0 : top;
  assign stack_count = count;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_IDLE) || ($past(state) == S_FIX))
    else $error("result strobe from a working state");

  a_pop_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |=> (count == $past(count) - CNT_W'(1)))
    else $error("binary op did not drop one entry");

  a_push_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_PUSH && count < CNT_W'(STACK_DEPTH))
    |=> (count == $past(count) + CNT_W'(1)))
    else $error("push did not add one entry");
`endif

endmodule

// ===== tb/sv/stack_arithmetic_unit_checker.sv =====
// checker for the stack arithmetic unit: tracks requests, predicts each result and compares
module stack_arithmetic_unit_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [2:0]                        opcode,
  input  logic signed [sau_pkg::DATA_W-1:0] push_value,
  input  logic                              done,
  input  logic [1:0]                        status,
  input  logic signed [sau_pkg::DATA_W-1:0] top_value,
  input  logic [sau_pkg::CNT_W-1:0]         stack_count,
  output int                                errors,
  output int                                pending
);
  import sau_pkg::*;

  typedef struct {
    logic [1:0]        code;
    logic [DATA_W-1:0] top;
    logic [CNT_W-1:0]  depth;
  } outcome_t;

  outcome_t          outcome_q[$];
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_depth;

  function automatic logic [DATA_W-1:0] combine_entries(input logic [2:0] op,
                                                        input logic [DATA_W-1:0] left,
                                                        input logic [DATA_W-1:0] right);
    longint a;
    longint b;
    longint q;
    a = $signed(left);
    b = $signed(right);
    case (op)
      OP_ADD: return left + right;
      OP_SUB: return left - right;
      OP_MUL: return left * right;
      // 64-bit math keeps most-negative over minus one well defined
      OP_DIV: begin
        q = a / b;
        return q[DATA_W-1:0];
      end
      default: begin
        q = a % b;
        return q[DATA_W-1:0];
      end
    endcase
  endfunction

  function automatic outcome_t apply_request(input logic [2:0] op,
                                             input logic [DATA_W-1:0] val);
    outcome_t o;
    o.code = ST_OK;
    if (op == OP_PUSH) begin
      if (shadow_depth >= STACK_DEPTH) begin
        o.code = ST_FULL;
      end else begin
        shadow_stack[shadow_depth] = val;
        shadow_depth++;
      end
    end else if (op <= OP_MOD) begin
      if (shadow_depth < 2) begin
        o.code = ST_SHORT;
      end else if ((op == OP_DIV || op == OP_MOD) && shadow_stack[shadow_depth-1] == '0) begin
        o.code = ST_DIVZERO;
      end else begin
        shadow_stack[shadow_depth-2] = combine_entries(op, shadow_stack[shadow_depth-2],
                                                       shadow_stack[shadow_depth-1]);
        shadow_depth--;
      end
    end
    o.top   = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
    o.depth = CNT_W'(shadow_depth);
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      shadow_depth = 0;
      outcome_q.delete();
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting: status %0d top %0d count %0d",
                   $time, status, top_value, stack_count);
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.code) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.code, status);
          end
          if (top_value !== want.top) begin
            errors++;
            $display("%0t: top_value mismatch: expected %0d, actual %0d",
                     $time, $signed(want.top), top_value);
          end
          if (stack_count !== want.depth) begin
            errors++;
            $display("%0t: stack_count mismatch: expected %0d, actual %0d",
                     $time, want.depth, stack_count);
          end
        end
      end
      if (start && !busy) begin
        outcome_q.push_back(apply_request(opcode, push_value));
      end
    end
    pending <= outcome_q.size();
  end

endmodule

// ===== tb/sv/stack_arithmetic_unit_core_tb.sv =====
// testbench top for the stack arithmetic unit: clock, reset, request stimulus and verdict
module stack_arithmetic_unit_core_tb;
  import sau_pkg::*;

  localparam int RANDOM_ITEMS   = 1900;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;

  localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MINUS_ONE = '1;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic [2:0]               opcode;
  logic signed [DATA_W-1:0] push_value;
  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] top_value;
  logic [CNT_W-1:0]         stack_count;
  int                       errors;
  int                       pending;
  int                       quiet_cycles;
  bit                       no_gaps;

  stack_arithmetic_unit_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .push_value (push_value),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .top_value  (top_value),
    .stack_count(stack_count)
  );

  stack_arithmetic_unit_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .push_value (push_value),
    .done       (done),
    .status     (status),
    .top_value  (top_value),
    .stack_count(stack_count),
    .errors     (errors),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("stack_arithmetic_unit_core verification failed");
        $finish;
      end
    end
  end

  // operands lean on the corners: zero, extremes, minus one, small values
  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return INT_MIN;
      2:       return INT_MAX;
      3:       return MINUS_ONE;
      4:       return DATA_W'(1);
      5, 6:    return DATA_W'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_PUSH;
    if (r < 96) return 3'($urandom_range(OP_ADD, OP_MOD));
    return (r < 98) ? OP_SPARE_LO : OP_SPARE_HI;
  endfunction

  // holds the request until taken; start stays high for a back-to-back request
  task automatic issue(input logic [2:0] op, input logic [DATA_W-1:0] val);
    if (!no_gaps && $urandom_range(0, 99) < 31) begin
      start      <= 1'b0;
      opcode     <= 3'($urandom);
      push_value <= $urandom;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 20)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    push_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int next_drain;
    logic [2:0] op;
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_PUSH;
    push_value   = '0;
    no_gaps      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    issue(OP_ADD, '0);            // short stack when empty
    issue(OP_PUSH, INT_MIN);
    issue(OP_MOD, '0);            // short stack with one entry
    issue(OP_PUSH, MINUS_ONE);
    issue(OP_DIV, '0);            // most negative over minus one
    issue(OP_PUSH, MINUS_ONE);
    issue(OP_MOD, '0);            // remainder of that is zero
    issue(OP_PUSH, '0);
    issue(OP_DIV, '0);            // zero divisor
    issue(OP_MOD, MINUS_ONE);
    issue(OP_SUB, INT_MAX);
    issue(OP_PUSH, INT_MAX);
    issue(OP_PUSH, DATA_W'(1));
    issue(OP_ADD, '0);            // wraps to most negative
    issue(OP_PUSH, DATA_W'(-7));
    issue(OP_PUSH, DATA_W'(2));
    issue(OP_DIV, '0);            // truncates toward zero
    issue(OP_PUSH, DATA_W'(2));
    issue(OP_MOD, '0);            // remainder takes dividend sign
    issue(OP_PUSH, INT_MAX);
    issue(OP_MUL, '0);
    issue(OP_SPARE_LO, $urandom);
    issue(OP_SPARE_HI, $urandom);
    issue(OP_MUL, '1);
    issue(OP_SUB, '0);
    drain_results();

    sent       = 0;
    next_drain = 600;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = (sent >= 700 && sent < 1100);
      if ($urandom_range(0, 19) == 0) begin
        // fill past full, then fold the stack back down
        repeat (STACK_DEPTH + 3) begin
          issue(OP_PUSH, pick_operand());
          sent++;
        end
        repeat (STACK_DEPTH + 2) begin
          issue(3'($urandom_range(OP_ADD, OP_MOD)), pick_operand());
          sent++;
        end
      end else begin
        op = pick_opcode();
        issue(op, pick_operand());
        if (op <= OP_MOD) sent++;
      end
      if (sent >= next_drain) begin
        drain_results();
        next_drain += 600;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("stack_arithmetic_unit_core verification clean");
    end else begin
      $display("stack_arithmetic_unit_core verification failed");
    end
    $finish;
  end

endmodule
